### src/plh_pkg.sv
`default_nettype none

package plh_pkg;

    localparam int LANES_DEF       = 16;
    localparam int BINS_DEF        = 1024;
    localparam int CODE_WIDTH_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int SLOT_W      = 16;
    localparam int MAX_LANES   = 16;
    localparam int ROW_W       = SLOT_W * MAX_LANES;
    localparam int CMD_W       = 2;
    localparam int BIN_IDX_W   = 10;
    localparam int S_TDATA_W   = 272;
    localparam int BIN_COUNT_W = 36;
    localparam int DROP_W      = 32;
    localparam int RESULT_W    = BIN_COUNT_W + DROP_W;
    localparam int M_TDATA_W   = 72;
    localparam int DROP_INC_W  = $clog2(MAX_LANES + 1);

    localparam int RQ_DEPTH    = 4;
    localparam int RQ_PTR_W    = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W    = $clog2(RQ_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic count;
        logic clear;
    } lane_op_t;

endpackage

`default_nettype wire

### src/plh_lane.sv
`default_nettype none

module plh_lane #(
    parameter int BINS        = plh_pkg::BINS_DEF,
    parameter int COUNT_WIDTH = plh_pkg::COUNT_WIDTH_DEF,
    parameter int AW          = $clog2(plh_pkg::BINS_DEF)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire plh_pkg::lane_op_t      op,
    input  wire logic                   hit,
    input  wire logic [AW-1:0]          addr,
    input  wire logic [AW-1:0]          clr_addr,
    output logic      [COUNT_WIDTH-1:0] value
);

    logic [COUNT_WIDTH-1:0] mem_reg [BINS];
    logic [COUNT_WIDTH-1:0] rdata_reg;
    logic [AW-1:0]          s1_addr_reg;
    logic                   s1_inc_reg;
    logic                   lw_en_reg;
    logic [AW-1:0]          lw_addr_reg;
    logic [COUNT_WIDTH-1:0] lw_data_reg;

    logic                   we;
    logic [AW-1:0]          waddr;
    logic [COUNT_WIDTH-1:0] wdata;
    logic [COUNT_WIDTH-1:0] cur;
    logic [COUNT_WIDTH-1:0] cur_inc;

    // forward the write of the previous cycle, the read missed it
    assign cur     = (lw_en_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg : rdata_reg;
    assign cur_inc = (cur == '1) ? cur : cur + 1'b1;
    assign value   = cur;

    always_comb begin
        if (op.clear) begin
            we    = 1'b1;
            waddr = clr_addr;
            wdata = '0;
        end else begin
            we    = s1_inc_reg;
            waddr = s1_addr_reg;
            wdata = cur_inc;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[addr];
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_inc_reg <= 1'b0;
            lw_en_reg  <= 1'b0;
        end else begin
            s1_inc_reg <= op.count && hit;
            lw_en_reg  <= we;
        end
    end

    always_ff @(posedge aclk) begin
        s1_addr_reg <= addr;
        lw_addr_reg <= waddr;
        lw_data_reg <= wdata;
    end

endmodule

`default_nettype wire

### src/plh_sum.sv
`default_nettype none

module plh_sum #(
    parameter int LANES       = plh_pkg::LANES_DEF,
    parameter int COUNT_WIDTH = plh_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    input  wire logic                              in_range,
    input  wire logic [plh_pkg::DROP_W-1:0]        in_drop,
    input  wire logic [COUNT_WIDTH-1:0]            lane_value [LANES],
    output logic                                   out_valid,
    output logic      [plh_pkg::BIN_COUNT_W-1:0]   out_count,
    output logic      [plh_pkg::DROP_W-1:0]        out_drop
);

    localparam int NG = (LANES + 3) / 4;
    localparam int GW = COUNT_WIDTH + 2;
    localparam int SW = COUNT_WIDTH + 4;

    logic [COUNT_WIDTH-1:0] pad [NG*4];
    logic [GW-1:0]          grp [NG];
    logic [SW-1:0]          total;

    logic                         a_valid_reg;
    logic                         a_range_reg;
    logic [plh_pkg::DROP_W-1:0]   a_drop_reg;
    logic [GW-1:0]                a_grp_reg [NG];

    logic                             b_valid_reg;
    logic [plh_pkg::BIN_COUNT_W-1:0]  b_count_reg;
    logic [plh_pkg::DROP_W-1:0]       b_drop_reg;

    always_comb begin
        for (int i = 0; i < NG * 4; i++) begin
            pad[i] = '0;
        end
        for (int i = 0; i < LANES; i++) begin
            pad[i] = lane_value[i];
        end
        for (int g = 0; g < NG; g++) begin
            grp[g] = GW'(pad[4*g]) + GW'(pad[4*g+1]) + GW'(pad[4*g+2]) + GW'(pad[4*g+3]);
        end
    end

    always_comb begin
        total = '0;
        for (int g = 0; g < NG; g++) begin
            total = total + SW'(a_grp_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_range_reg <= in_range;
        a_drop_reg  <= in_drop;
        for (int g = 0; g < NG; g++) begin
            a_grp_reg[g] <= grp[g];
        end
        b_count_reg <= a_range_reg ? plh_pkg::BIN_COUNT_W'(total) : '0;
        b_drop_reg  <= a_drop_reg;
    end

    assign out_valid = b_valid_reg;
    assign out_count = b_count_reg;
    assign out_drop  = b_drop_reg;

endmodule

`default_nettype wire

### src/plh_result_q.sv
`default_nettype none

module plh_result_q (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    input  wire logic [plh_pkg::RESULT_W-1:0]  push_data,
    output logic                               pop_valid,
    input  wire logic                          pop_ready,
    output logic      [plh_pkg::RESULT_W-1:0]  pop_data
);

    logic [plh_pkg::RESULT_W-1:0] q_reg [plh_pkg::RQ_DEPTH];
    logic [plh_pkg::RQ_PTR_W-1:0] wr_ptr_reg;
    logic [plh_pkg::RQ_PTR_W-1:0] rd_ptr_reg;
    logic [plh_pkg::RQ_CNT_W-1:0] cnt_reg;
    logic [plh_pkg::RQ_CNT_W-1:0] cnt_next;
    logic                         pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = q_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### src/parallel_lane_histogram_unit.sv
// Channel  Bus             Contents (lowest bit up)
// s_       tdata  [271:0]  row_part_0..3 [255:0], bin_index [265:256], zero pad
//          tuser  [1:0]    cmd
// m_       tdata  [71:0]   bin_count [35:0], dropped_codes [67:36], zero pad
//
// A count request is taken every cycle while s_tready is high; each lane
// updates its own memory by read, increment and write back, with the
// previous write forwarded. m_tvalid rises after a read request is accepted,
// once it has passed the lane read, two adder stages and the result queue.
// At most 4 reads are outstanding, in flight or waiting on m_; with 4 outstanding
// s_tready is low.
// After reset and after a clear request, a clearing pass over all BINS addresses
// (1024 by default) zeroes one row of all lanes per cycle with s_tready low.
`default_nettype none

module parallel_lane_histogram_unit #(
    parameter int LANES       = plh_pkg::LANES_DEF,
    parameter int BINS        = plh_pkg::BINS_DEF,
    parameter int CODE_WIDTH  = plh_pkg::CODE_WIDTH_DEF,
    parameter int COUNT_WIDTH = plh_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [plh_pkg::S_TDATA_W-1:0]   s_tdata,  // row_part_0..3, bin_index
    input  wire logic [plh_pkg::CMD_W-1:0]       s_tuser,  // cmd
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [plh_pkg::M_TDATA_W-1:0]   m_tdata   // bin_count, dropped_codes
);

    localparam int AW = $clog2(BINS);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    state_t                          state_reg, state_next;
    logic [AW-1:0]                   clr_addr_reg, clr_addr_next;
    logic [plh_pkg::RQ_CNT_W-1:0]    pend_reg, pend_next;
    logic [plh_pkg::DROP_W-1:0]      drop_reg, drop_next;
    logic                            s1_rd_reg;
    logic                            s1_inr_reg;
    logic [plh_pkg::DROP_W-1:0]      s1_drop_reg;

    logic                            accept;
    logic                            pop;
    logic                            is_clr, is_cnt, is_rd;
    plh_pkg::cmd_t                   cmd;
    logic [plh_pkg::ROW_W-1:0]       row;
    logic [plh_pkg::BIN_IDX_W-1:0]   bin_index;
    logic                            bin_inr;
    logic [AW-1:0]                   bin_addr;
    logic [CODE_WIDTH-1:0]           code [LANES];
    logic                            hit  [LANES];
    logic [plh_pkg::DROP_INC_W-1:0]  drop_inc;
    logic [plh_pkg::DROP_W:0]        drop_sum;
    plh_pkg::lane_op_t               lane_op;
    logic [COUNT_WIDTH-1:0]          lane_value [LANES];

    logic                            sum_valid;
    logic [plh_pkg::BIN_COUNT_W-1:0] sum_count;
    logic [plh_pkg::DROP_W-1:0]      sum_drop;
    logic [plh_pkg::RESULT_W-1:0]    q_data;

    assign accept    = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;
    assign cmd       = plh_pkg::cmd_t'(s_tuser);
    assign row       = s_tdata[plh_pkg::ROW_W-1:0];
    assign bin_index = s_tdata[plh_pkg::ROW_W +: plh_pkg::BIN_IDX_W];
    assign bin_inr   = (32'(bin_index) < 32'(BINS));
    assign bin_addr  = AW'(bin_index);
    assign s_tready  = (state_reg == ST_RUN) && (pend_reg != plh_pkg::RQ_CNT_W'(plh_pkg::RQ_DEPTH));

    always_comb begin
        is_clr = 1'b0;
        is_cnt = 1'b0;
        is_rd  = 1'b0;
        unique case (cmd)
            plh_pkg::CMD_CLEAR: is_clr = 1'b1;
            plh_pkg::CMD_COUNT: is_cnt = 1'b1;
            plh_pkg::CMD_READ:  is_rd  = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        drop_inc = '0;
        for (int l = 0; l < LANES; l++) begin
            code[l]  = row[l*plh_pkg::SLOT_W +: CODE_WIDTH];
            hit[l]   = (32'(code[l]) < 32'(BINS));
            drop_inc = drop_inc + plh_pkg::DROP_INC_W'(!hit[l]);
        end
        drop_sum = {1'b0, drop_reg} + (plh_pkg::DROP_W + 1)'(drop_inc);
    end

    assign lane_op.count = accept && is_cnt;
    assign lane_op.clear = (state_reg == ST_CLEAR);

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(BINS - 1)) begin
                    state_next    = ST_RUN;
                    clr_addr_next = '0;
                end
            end
            ST_RUN: begin
                if (accept && is_clr) begin
                    state_next = ST_CLEAR;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        drop_next = drop_reg;
        if (accept && is_clr) begin
            drop_next = '0;
        end else if (accept && is_cnt) begin
            drop_next = drop_sum[plh_pkg::DROP_W] ? '1 : drop_sum[plh_pkg::DROP_W-1:0];
        end
    end

    always_comb begin
        case ({accept && is_rd, pop})
            2'b10:   pend_next = pend_reg + 1'b1;
            2'b01:   pend_next = pend_reg - 1'b1;
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= '0;
            drop_reg     <= '0;
            s1_rd_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            drop_reg     <= drop_next;
            s1_rd_reg    <= accept && is_rd;
        end
    end

    always_ff @(posedge aclk) begin
        s1_inr_reg  <= bin_inr;
        s1_drop_reg <= drop_reg;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        plh_lane #(
            .BINS        (BINS),
            .COUNT_WIDTH (COUNT_WIDTH),
            .AW          (AW)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .op       (lane_op),
            .hit      (hit[l]),
            .addr     (is_rd ? bin_addr : AW'(code[l])),
            .clr_addr (clr_addr_reg),
            .value    (lane_value[l])
        );
    end

    plh_sum #(
        .LANES       (LANES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_sum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s1_rd_reg),
        .in_range   (s1_inr_reg),
        .in_drop    (s1_drop_reg),
        .lane_value (lane_value),
        .out_valid  (sum_valid),
        .out_count  (sum_count),
        .out_drop   (sum_drop)
    );

    plh_result_q u_result_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (sum_valid),
        .push_data ({sum_drop, sum_count}),
        .pop_valid (m_tvalid),
        .pop_ready (m_tready),
        .pop_data  (q_data)
    );

    assign m_tdata = {{(plh_pkg::M_TDATA_W - plh_pkg::RESULT_W){1'b0}}, q_data};

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("request taken during clearing pass");

    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= plh_pkg::RQ_CNT_W'(plh_pkg::RQ_DEPTH))
        else $error("read results outstanding beyond queue depth");

    a_result_has_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pend_reg != '0))
        else $error("result shown without an outstanding read");

    a_drop_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && is_clr) |=> (drop_reg >= $past(drop_reg)))
        else $error("dropped count fell without a clear");

    a_clear_leaves_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_clr) |=> (drop_reg == '0) && (state_reg == ST_CLEAR))
        else $error("clear request did not start clearing pass");
`endif

endmodule

`default_nettype wire
